### sv/julia_pkg.sv
// shared types, register codes and fixed-point helpers for the julia escape-time engine
package julia_pkg;

    localparam int COORD_W   = 32;
    localparam int STEP_W    = 31;
    localparam int IDX_W     = 12;
    localparam int ITER_BITS = 16;
    localparam int PAL_W     = 8;
    localparam int PaletteEntries = 256;
    localparam int FRAC_BITS = 28;
    localparam int PROD_W    = 2 * COORD_W;
    localparam int WIDE_W    = 48;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_C_REAL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_C_IMAG   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 3'd6;

    // reset values
    localparam logic signed [COORD_W-1:0] X_ORIGIN_RST = -32'sd402653184;
    localparam logic signed [COORD_W-1:0] Y_ORIGIN_RST = 32'sd402653184;
    localparam logic [STEP_W-1:0]         STEP_X_RST   = 31'd786432;
    localparam logic [STEP_W-1:0]         STEP_Y_RST   = 31'd786432;
    localparam logic signed [COORD_W-1:0] C_REAL_RST   = -32'sd214748365;
    localparam logic signed [COORD_W-1:0] C_IMAG_RST   = 32'sd42949673;
    localparam logic [ITER_BITS-1:0]      MAX_ITER_RST = 16'd256;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_origin;
        logic signed [COORD_W-1:0] y_origin;
        logic [STEP_W-1:0]         step_x;
        logic [STEP_W-1:0]         step_y;
        logic signed [COORD_W-1:0] c_real;
        logic signed [COORD_W-1:0] c_imag;
        logic [ITER_BITS-1:0]      max_iter;
    } cfg_t;

    // one pixel in flight, handed from cell to cell
    typedef struct packed {
        logic                      valid;
        logic                      done;
        logic signed [COORD_W-1:0] zr;
        logic signed [COORD_W-1:0] zi;
        logic [ITER_BITS-1:0]      count;
        logic [IDX_W-1:0]          column;
        logic [IDX_W-1:0]          row;
    } link_t;

    // clamp a wide signed value to the q4.28 range
    function automatic logic signed [COORD_W-1:0] sat_q(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = {{(WIDE_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
        lo = {{(WIDE_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};
        if (v > hi)
            return hi[COORD_W-1:0];
        else if (v < lo)
            return lo[COORD_W-1:0];
        else
            return v[COORD_W-1:0];
    endfunction

endpackage

### sv/julia_escape_time_pixel.sv
// top level of the julia escape-time pixel engine: start-point mapping, cell ring, result register
//
// usage
//   s_* channel takes one word per pixel: column and row. m_* channel returns one word per
//   pixel: the pixel coordinates echoed, the final iteration count, the escaped flag and
//   the palette index (zero for bounded pixels). cfg_we/cfg_index/cfg_data write the
//   seven registers (origin, steps, julia constant, iteration limit); write them only
//   while no pixel is in flight.
//   on acceptance the pixel is mapped to its start point and held in a start register; the
//   next cycle it enters a ring of CELLS iteration cells, each doing one z = z^2 + c step
//   in two register stages. one pixel is in the ring at a time. a pixel with final count n
//   needs n cell passes, rounded up to whole laps of the ring, before its result is
//   registered; the next pixel is accepted only after the previous one has left the ring.
//   the two-stage squaring in each cell and the single pixel in the ring set the pixel rate.
//   a finished result waits in the output register; the next pixel is accepted while it
//   waits. if the receiver stalls longer, the finished pixel keeps circling the ring
//   (unchanged) and s_tready stays low until the output register frees up.
//   reset restores the register defaults, empties the ring and drops any result.
module julia_escape_time_pixel #(
    parameter int CELLS = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    // slave side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // column[11:0], row[23:12]
    // master side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // pixel_column[11:0], pixel_row[23:12],
                                   // iteration_count[39:24], escaped[40],
                                   // palette_index[48:41], zero fill[55:49]
    // configuration
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int CW = julia_pkg::COORD_W;
    localparam int IW = julia_pkg::IDX_W;
    localparam int SW = julia_pkg::STEP_W;
    localparam int WW = julia_pkg::WIDE_W;
    localparam int NW = julia_pkg::ITER_BITS;
    localparam int PW = julia_pkg::PAL_W;

    julia_pkg::cfg_t  cfg;
    julia_pkg::link_t link [CELLS+1];
    logic [CELLS-1:0] ring_vld;

    logic             busy_reg;
    logic             busy_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [55:0]      out_data_reg;
    logic [55:0]      out_data_next;
    julia_pkg::link_t start_reg;
    julia_pkg::link_t start_next;

    logic             accept;
    logic             capture;
    julia_pkg::link_t last;
    julia_pkg::link_t start;
    logic [IW-1:0]    in_col;
    logic [IW-1:0]    in_row;
    logic [IW+SW-1:0] col_off;
    logic [IW+SW-1:0] row_off;
    logic signed [WW-1:0] x_wide;
    logic signed [WW-1:0] y_wide;
    logic             esc;
    logic [PW-1:0]    pal;

    julia_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // ------------------------------------------------------------------
    // start point: column and row already lie inside the frame dimension
    // ------------------------------------------------------------------
    assign in_col  = s_tdata[IW-1:0];
    assign in_row  = s_tdata[2*IW-1:IW];
    assign col_off = in_col * cfg.step_x;
    assign row_off = in_row * cfg.step_y;
    assign x_wide  = {{(WW-CW){cfg.x_origin[CW-1]}}, cfg.x_origin}
                   + {{(WW-IW-SW){1'b0}}, col_off};
    assign y_wide  = {{(WW-CW){cfg.y_origin[CW-1]}}, cfg.y_origin}
                   - {{(WW-IW-SW){1'b0}}, row_off};

    always_comb
    begin
        start        = '0;
        start.valid  = 1'b1;
        start.zr     = julia_pkg::sat_q(x_wide);
        start.zi     = julia_pkg::sat_q(y_wide);
        start.count  = NW'(1);
        start.column = in_col;
        start.row    = in_row;
    end

    // the mapped start point is registered before the first squaring
    assign start_next = accept ? start : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
        end
        else
        begin
            start_reg <= start_next;
        end
    end

    // ------------------------------------------------------------------
    // ring of iteration cells
    // ------------------------------------------------------------------
    assign last     = link[CELLS];
    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && s_tready;
    // a finished pixel leaves the ring only when the result register is free
    assign capture  = last.valid && last.done && (!out_valid_reg || m_tready);

    assign link[0] = start_reg.valid ? start_reg
                   : ((last.valid && !capture) ? last : '0);

    for (genvar g = 0; g < CELLS; g++)
    begin : g_cell
        julia_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cfg      (cfg),
            .link_in  (link[g]),
            .link_out (link[g+1])
        );
        assign ring_vld[g] = link[g+1].valid;
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    assign esc = last.count < cfg.max_iter;
    // palette size is a power of two, so the remainder is the low bits
    assign pal = esc ? PW'(last.count % julia_pkg::PaletteEntries) : '0;

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
            busy_next = 1'b1;
        else if (capture)
            busy_next = 1'b0;

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (capture)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {7'd0, pal, esc, last.count, last.row, last.column};
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // at most one pixel is ever in the ring
    a_single_word: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(ring_vld))
        else $error("more than one word in the cell ring");

    // with no pixel in flight the ring is empty
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (ring_vld == '0))
        else $error("cell ring holds a word while idle");

    // a captured pixel shows up on the output the next cycle
    a_capture_out: assert property (@(posedge clk) disable iff (!rst_n)
        capture |=> (m_tvalid && !busy_reg))
        else $error("finished word not presented");

    // the iteration count never drops below one on a live word
    a_count_min: assert property (@(posedge clk) disable iff (!rst_n)
        last.valid |-> (last.count != '0))
        else $error("iteration count of zero in the ring");

endmodule

### sv/julia_cfg.sv
// configuration register file of the julia escape-time engine
module julia_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [julia_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [julia_pkg::CFG_DATA_W-1:0]   cfg_data,
    output julia_pkg::cfg_t                    cfg
);

    julia_pkg::cfg_t cfg_reg;
    julia_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                julia_pkg::REG_X_ORIGIN: cfg_next.x_origin = cfg_data;
                julia_pkg::REG_Y_ORIGIN: cfg_next.y_origin = cfg_data;
                julia_pkg::REG_STEP_X:   cfg_next.step_x   = cfg_data[julia_pkg::STEP_W-1:0];
                julia_pkg::REG_STEP_Y:   cfg_next.step_y   = cfg_data[julia_pkg::STEP_W-1:0];
                julia_pkg::REG_C_REAL:   cfg_next.c_real   = cfg_data;
                julia_pkg::REG_C_IMAG:   cfg_next.c_imag   = cfg_data;
                julia_pkg::REG_MAX_ITER: cfg_next.max_iter = cfg_data[julia_pkg::ITER_BITS-1:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_origin <= julia_pkg::X_ORIGIN_RST;
            cfg_reg.y_origin <= julia_pkg::Y_ORIGIN_RST;
            cfg_reg.step_x   <= julia_pkg::STEP_X_RST;
            cfg_reg.step_y   <= julia_pkg::STEP_Y_RST;
            cfg_reg.c_real   <= julia_pkg::C_REAL_RST;
            cfg_reg.c_imag   <= julia_pkg::C_IMAG_RST;
            cfg_reg.max_iter <= julia_pkg::MAX_ITER_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### sv/julia_cell.sv
// one iteration cell: squares z in its first stage, tests and updates in its second
module julia_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  julia_pkg::cfg_t   cfg,
    input  julia_pkg::link_t  link_in,
    output julia_pkg::link_t  link_out
);

    localparam int PW = julia_pkg::PROD_W;
    localparam int WW = julia_pkg::WIDE_W;
    localparam int FB = julia_pkg::FRAC_BITS;

    julia_pkg::link_t      a_reg;
    julia_pkg::link_t      b_reg;
    julia_pkg::link_t      b_next;
    logic signed [PW-1:0]  rr_reg;
    logic signed [PW-1:0]  ii_reg;
    logic signed [PW-1:0]  ri_reg;

    logic [PW-1:0]         mag;
    logic signed [PW-1:0]  diff;
    logic signed [WW-1:0]  nr_wide;
    logic signed [WW-1:0]  ni_wide;
    logic                  keep_going;

    // stage one: the three products at full width
    always_ff @(posedge clk)
    begin
        rr_reg <= PW'(link_in.zr * link_in.zr);
        ii_reg <= PW'(link_in.zi * link_in.zi);
        ri_reg <= PW'(link_in.zr * link_in.zi);
    end

    // stage two: escape test, then z squared plus c with floor rounding
    always_comb
    begin
        mag  = $unsigned(rr_reg) + $unsigned(ii_reg);
        diff = rr_reg - ii_reg;
        nr_wide = {{(WW-PW+FB){diff[PW-1]}}, diff[PW-1:FB]}
                + {{(WW-julia_pkg::COORD_W){cfg.c_real[julia_pkg::COORD_W-1]}}, cfg.c_real};
        ni_wide = {{(WW-PW+FB-1){ri_reg[PW-1]}}, ri_reg[PW-1:FB-1]}
                + {{(WW-julia_pkg::COORD_W){cfg.c_imag[julia_pkg::COORD_W-1]}}, cfg.c_imag};
        // |z|^2 below 4.0 means the top six bits of the q8.56 sum are clear
        keep_going = (a_reg.count < cfg.max_iter) && (mag[PW-1:58] == '0);

        b_next = a_reg;
        if (a_reg.valid && !a_reg.done)
        begin
            if (keep_going)
            begin
                b_next.zr    = julia_pkg::sat_q(nr_wide);
                b_next.zi    = julia_pkg::sat_q(ni_wide);
                b_next.count = a_reg.count + 1'b1;
            end
            else
            begin
                b_next.done = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= '0;
            b_reg <= '0;
        end
        else
        begin
            a_reg <= link_in;
            b_reg <= b_next;
        end
    end

    assign link_out = b_reg;

endmodule
